// ----- rtl/core/rrms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrms_pkg
// Types, codes and constants shared by the roam mode sequencer files.
// ----------------------------------------------------------------------------
package rrms_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_HIGH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH = 2'd3;

	localparam logic [6:0] RST_DRIVE_LOW   = 7'd30;
	localparam logic [6:0] RST_DRIVE_HIGH  = 7'd40;
	localparam logic [6:0] RST_ROTATE_HIGH = 7'd40;
	localparam int         RST_NEAR_THRESH = 100;

	typedef enum logic [2:0] {
		OP_TICK          = 3'd0,
		OP_START         = 3'd1,
		OP_HALT          = 3'd2,
		OP_MANUAL_DRIVE  = 3'd3,
		OP_MANUAL_ROTATE = 3'd4,
		OP_MANUAL_HALT   = 3'd5,
		OP_READ_EVENT    = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE          = 3'd0,
		CMD_STOP          = 3'd1,
		CMD_DRIVE_SPEED   = 3'd2,
		CMD_ROTATE_SPEED  = 3'd3,
		CMD_DRIVE_DIST    = 3'd4,
		CMD_ROTATE_ANGLE  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_AUTO   = 2'd1,
		MODE_MANUAL = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PAT_FORWARD = 2'd0,
		PAT_BACKOFF = 2'd1,
		PAT_RECOVER = 2'd2
	} pattern_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_CLOSE    = 2'd1,
		EV_BOUNDARY = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		FWD_BEGIN = 2'd0,
		FWD_DRIVE = 2'd1,
		FWD_WAIT  = 2'd2
	} fwd_step_t;

	// shared by the backoff and the boundary recovery patterns
	typedef enum logic [2:0] {
		SEQ_BEGIN     = 3'd0,
		SEQ_STOP      = 3'd1,
		SEQ_WAIT_STOP = 3'd2,
		SEQ_MOVE      = 3'd3,
		SEQ_WAIT_MOVE = 3'd4,
		SEQ_TURN      = 3'd5,
		SEQ_WAIT_TURN = 3'd6
	} seq_step_t;

	localparam logic [1:0] HEAD_FORWARD = 2'd1;
	localparam logic [1:0] HEAD_REVERSE = 2'd2;

	typedef struct packed {
		mode_t      mode;
		pattern_t   pattern;
		fwd_step_t  fwd_step;
		seq_step_t  bko_step;
		seq_step_t  rec_step;
		logic [1:0] heading;
		event_t     evt;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode:     MODE_IDLE,
		pattern:  PAT_FORWARD,
		fwd_step: FWD_BEGIN,
		bko_step: SEQ_BEGIN,
		rec_step: SEQ_BEGIN,
		heading:  2'd0,
		evt:      EV_NONE
	};

	typedef struct packed {
		logic [6:0] drive_low;
		logic [6:0] drive_high;
		logic [6:0] rotate_high;
	} speed_cfg_t;

	// angle ranges: low end and span
	localparam logic signed [8:0] BKO_POS_LOW = 9'sd90;
	localparam logic signed [8:0] BKO_NEG_LOW = -9'sd120;
	localparam logic [6:0]        BKO_SPAN    = 7'd30;
	localparam logic signed [8:0] REC_POS_LOW = 9'sd45;
	localparam logic signed [8:0] REC_NEG_LOW = -9'sd135;
	localparam logic [6:0]        REC_SPAN    = 7'd90;
	localparam logic signed [8:0] REV_LOW     = -9'sd60;
	localparam logic [6:0]        REV_SPAN    = 7'd120;

	localparam logic signed [8:0] BKO_DIST     = -9'sd200;
	localparam logic signed [8:0] REC_FWD_DIST = -9'sd100;
	localparam logic signed [8:0] REC_REV_DIST = 9'sd200;

	function automatic logic signed [8:0] rand_angle(
		input logic signed [8:0] low,
		input logic [6:0]        span,
		input logic [6:0]        pick
	);
		logic [6:0] off;
		off = (pick < span) ? pick : span;
		return low + $signed({2'b00, off});
	endfunction

endpackage

// ----- rtl/core/rrms_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrms_item_if
// Request channel: opcode plus sensor and driver status.
// ----------------------------------------------------------------------------
interface rrms_item_if #(
	parameter int PROX_BITS = 10
) ();
	logic                 valid;
	logic                 ready;
	logic [2:0]           opcode;
	logic signed [7:0]    manual_speed;
	logic [PROX_BITS-1:0] proximity;
	logic                 off_boundary;
	logic                 driver_idle;
	logic [1:0]           driver_heading;
	logic                 coin;
	logic [6:0]           pick;

	modport source (
		output valid, opcode, manual_speed, proximity, off_boundary,
		       driver_idle, driver_heading, coin, pick,
		input  ready
	);
	modport sink (
		input  valid, opcode, manual_speed, proximity, off_boundary,
		       driver_idle, driver_heading, coin, pick,
		output ready
	);
endinterface

// ----- rtl/core/rrms_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrms_result_if
// Result channel: motor command, mode and latched event.
// ----------------------------------------------------------------------------
interface rrms_result_if ();
	logic              valid;
	logic              ready;
	logic [2:0]        command;
	logic signed [8:0] amount;
	logic [6:0]        speed;
	logic [1:0]        mode;
	logic [1:0]        event_res;

	modport source (
		output valid, command, amount, speed, mode, event_res,
		input  ready
	);
	modport sink (
		input  valid, command, amount, speed, mode, event_res,
		output ready
	);
endinterface

// ----- rtl/core/rrms_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrms_step
// Next-state and command logic for one request of the mode sequencer.
// ----------------------------------------------------------------------------
module rrms_step #(
	parameter int PROX_BITS = 10
) (
	input  rrms_pkg::state_t     st,
	input  rrms_pkg::speed_cfg_t spd_cfg,
	input  logic [PROX_BITS-1:0] near_threshold,
	input  logic [2:0]           opcode,
	input  logic signed [7:0]    manual_speed,
	input  logic [PROX_BITS-1:0] proximity,
	input  logic                 off_boundary,
	input  logic                 driver_idle,
	input  logic [1:0]           driver_heading,
	input  logic                 coin,
	input  logic [6:0]           pick,
	output rrms_pkg::state_t     st_nxt,
	output logic [2:0]           command,
	output logic signed [8:0]    amount,
	output logic [6:0]           speed,
	output logic [1:0]           mode,
	output logic [1:0]           event_res
);
	import rrms_pkg::*;

	logic   near;
	op_t    op;
	state_t nxt;
	cmd_t   cmd;
	logic signed [8:0] amt;
	logic [6:0] spd;
	logic signed [8:0] angle;

	assign near = proximity < near_threshold;
	assign op   = op_t'(opcode);

	always_comb begin
		nxt   = st;
		cmd   = CMD_NONE;
		amt   = '0;
		spd   = '0;
		angle = '0;
		unique case (op)
			OP_TICK: begin
				if (st.mode == MODE_AUTO) begin
					unique case (st.pattern)
						PAT_FORWARD: begin
							unique case (st.fwd_step)
								FWD_BEGIN: nxt.fwd_step = FWD_DRIVE;
								FWD_DRIVE: begin
									cmd = CMD_DRIVE_SPEED;
									amt = $signed({2'b00, spd_cfg.drive_high});
									nxt.fwd_step = FWD_WAIT;
								end
								FWD_WAIT: begin
									if (near) begin
										nxt.evt      = EV_CLOSE;
										nxt.bko_step = SEQ_BEGIN;
										nxt.pattern  = PAT_BACKOFF;
									end
									// boundary wins when both show up
									if (off_boundary) begin
										nxt.evt      = EV_BOUNDARY;
										nxt.rec_step = SEQ_BEGIN;
										nxt.pattern  = PAT_RECOVER;
									end
								end
								default: ;
							endcase
						end
						PAT_BACKOFF: begin
							unique case (st.bko_step)
								SEQ_BEGIN: nxt.bko_step = SEQ_STOP;
								SEQ_STOP: begin
									cmd = CMD_STOP;
									nxt.bko_step = SEQ_WAIT_STOP;
								end
								SEQ_WAIT_STOP: if (driver_idle) nxt.bko_step = SEQ_MOVE;
								SEQ_MOVE: begin
									cmd = CMD_DRIVE_DIST;
									amt = BKO_DIST;
									spd = spd_cfg.drive_low;
									nxt.bko_step = SEQ_WAIT_MOVE;
								end
								SEQ_WAIT_MOVE: begin
									if (off_boundary) begin
										nxt.evt      = EV_BOUNDARY;
										nxt.rec_step = SEQ_BEGIN;
										nxt.pattern  = PAT_RECOVER;
									end
									if (driver_idle) nxt.bko_step = SEQ_TURN;
								end
								SEQ_TURN: begin
									cmd = CMD_ROTATE_ANGLE;
									amt = coin ? rand_angle(BKO_POS_LOW, BKO_SPAN, pick)
									           : rand_angle(BKO_NEG_LOW, BKO_SPAN, pick);
									spd = spd_cfg.rotate_high;
									nxt.bko_step = SEQ_WAIT_TURN;
								end
								SEQ_WAIT_TURN: begin
									if (driver_idle) begin
										nxt.fwd_step = FWD_BEGIN;
										nxt.pattern  = PAT_FORWARD;
									end
								end
								default: ;
							endcase
						end
						PAT_RECOVER: begin
							unique case (st.rec_step)
								SEQ_BEGIN: begin
									nxt.heading  = driver_heading;
									nxt.rec_step = SEQ_STOP;
								end
								SEQ_STOP: begin
									cmd = CMD_STOP;
									nxt.rec_step = SEQ_WAIT_STOP;
								end
								SEQ_WAIT_STOP: if (driver_idle) nxt.rec_step = SEQ_MOVE;
								SEQ_MOVE: begin
									// stopped or bad heading: no move at all
									if (st.heading == HEAD_FORWARD) begin
										cmd = CMD_DRIVE_DIST;
										amt = REC_FWD_DIST;
										spd = spd_cfg.drive_low;
									end else if (st.heading == HEAD_REVERSE) begin
										cmd = CMD_DRIVE_DIST;
										amt = REC_REV_DIST;
										spd = spd_cfg.drive_low;
									end
									nxt.rec_step = SEQ_WAIT_MOVE;
								end
								SEQ_WAIT_MOVE: begin
									if (near) begin
										nxt.evt      = EV_CLOSE;
										nxt.bko_step = SEQ_BEGIN;
										nxt.pattern  = PAT_BACKOFF;
									end
									if (driver_idle) nxt.rec_step = SEQ_TURN;
								end
								SEQ_TURN: begin
									if (st.heading == HEAD_FORWARD)
										angle = coin ? rand_angle(REC_POS_LOW, REC_SPAN, pick)
										             : rand_angle(REC_NEG_LOW, REC_SPAN, pick);
									else if (st.heading == HEAD_REVERSE)
										angle = rand_angle(REV_LOW, REV_SPAN, pick);
									cmd = CMD_ROTATE_ANGLE;
									amt = angle;
									spd = spd_cfg.rotate_high;
									nxt.rec_step = SEQ_WAIT_TURN;
								end
								SEQ_WAIT_TURN: begin
									if (driver_idle) begin
										nxt.fwd_step = FWD_BEGIN;
										nxt.pattern  = PAT_FORWARD;
									end
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end else if (st.mode == MODE_MANUAL) begin
					if (near && driver_heading == HEAD_FORWARD) begin
						nxt.evt  = EV_CLOSE;
						cmd      = CMD_STOP;
						nxt.mode = MODE_IDLE;
					end
				end
			end
			OP_START: begin
				if (st.mode == MODE_IDLE) begin
					nxt.fwd_step = FWD_BEGIN;
					nxt.pattern  = PAT_FORWARD;
					nxt.mode     = MODE_AUTO;
				end
			end
			OP_HALT: begin
				if (st.mode == MODE_AUTO) begin
					cmd      = CMD_STOP;
					nxt.mode = MODE_IDLE;
				end
			end
			OP_MANUAL_DRIVE, OP_MANUAL_ROTATE: begin
				if (st.mode == MODE_IDLE || st.mode == MODE_MANUAL) begin
					cmd      = (op == OP_MANUAL_DRIVE) ? CMD_DRIVE_SPEED : CMD_ROTATE_SPEED;
					amt      = 9'(manual_speed);
					nxt.mode = MODE_MANUAL;
				end
			end
			OP_MANUAL_HALT: begin
				if (st.mode == MODE_MANUAL) begin
					cmd      = CMD_STOP;
					nxt.mode = MODE_IDLE;
				end
			end
			OP_READ_EVENT: ;
			default: ;
		endcase

		event_res = nxt.evt;
		if (op == OP_READ_EVENT)
			nxt.evt = EV_NONE;
	end

	assign st_nxt  = nxt;
	assign command = cmd;
	assign amount  = amt;
	assign speed   = spd;
	assign mode    = nxt.mode;

endmodule

// ----- rtl/core/robot_roam_mode_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_roam_mode_sequencer
// Idle / autonomous / manual mode sequencer of a roaming robot.
// ----------------------------------------------------------------------------
// Takes one request per clock while no result is stalled and returns exactly
// one result per request, in order. A request is registered on acceptance
// and its result lands in the output register once that register is empty
// or being taken. Sustained rate is one request per cycle: the whole mode and
// pattern step is a single pass of compare and select logic between the
// request register and the result register, and the sequencer state updates
// on the same edge. A stalled result holds the pipe; a new request is still
// taken while the request register is empty. Write the registers through
// cfg_we/cfg_index/cfg_data only while no request is in flight (the block does
// not enforce this); the speed registers take the low seven bits of cfg_data.
module robot_roam_mode_sequencer #(
	parameter int PROX_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rrms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [PROX_BITS-1:0]            cfg_data,
	rrms_item_if.sink                       item,
	rrms_result_if.source                   result
);
	import rrms_pkg::*;

	speed_cfg_t           spd_cfg_q;
	logic [PROX_BITS-1:0] near_threshold_q;
	state_t               state_q;
	state_t               state_nxt;

	logic                 valid_s1;
	logic [2:0]           opcode_s1;
	logic signed [7:0]    manual_speed_s1;
	logic [PROX_BITS-1:0] proximity_s1;
	logic                 off_boundary_s1;
	logic                 driver_idle_s1;
	logic [1:0]           driver_heading_s1;
	logic                 coin_s1;
	logic [6:0]           pick_s1;

	logic                 valid_s2;
	logic [2:0]           command_s2;
	logic signed [8:0]    amount_s2;
	logic [6:0]           speed_s2;
	logic [1:0]           mode_s2;
	logic [1:0]           event_res_s2;

	logic [2:0]           command_c;
	logic signed [8:0]    amount_c;
	logic [6:0]           speed_c;
	logic [1:0]           mode_c;
	logic [1:0]           event_res_c;

	logic                 advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_cfg_q.drive_low   <= RST_DRIVE_LOW;
			spd_cfg_q.drive_high  <= RST_DRIVE_HIGH;
			spd_cfg_q.rotate_high <= RST_ROTATE_HIGH;
			near_threshold_q      <= PROX_BITS'(RST_NEAR_THRESH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRIVE_LOW:   spd_cfg_q.drive_low   <= cfg_data[6:0];
				CFG_DRIVE_HIGH:  spd_cfg_q.drive_high  <= cfg_data[6:0];
				CFG_ROTATE_HIGH: spd_cfg_q.rotate_high <= cfg_data[6:0];
				CFG_NEAR_THRESH: near_threshold_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// control: stage valids and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (item.ready)
				valid_s1 <= item.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1         <= item.opcode;
			manual_speed_s1   <= item.manual_speed;
			proximity_s1      <= item.proximity;
			off_boundary_s1   <= item.off_boundary;
			driver_idle_s1    <= item.driver_idle;
			driver_heading_s1 <= item.driver_heading;
			coin_s1           <= item.coin;
			pick_s1           <= item.pick;
		end
		if (advance) begin
			command_s2   <= command_c;
			amount_s2    <= amount_c;
			speed_s2     <= speed_c;
			mode_s2      <= mode_c;
			event_res_s2 <= event_res_c;
		end
	end

	rrms_step #(
		.PROX_BITS(PROX_BITS)
	) u_step (
		.st             (state_q),
		.spd_cfg        (spd_cfg_q),
		.near_threshold (near_threshold_q),
		.opcode         (opcode_s1),
		.manual_speed   (manual_speed_s1),
		.proximity      (proximity_s1),
		.off_boundary   (off_boundary_s1),
		.driver_idle    (driver_idle_s1),
		.driver_heading (driver_heading_s1),
		.coin           (coin_s1),
		.pick           (pick_s1),
		.st_nxt         (state_nxt),
		.command        (command_c),
		.amount         (amount_c),
		.speed          (speed_c),
		.mode           (mode_c),
		.event_res      (event_res_c)
	);

	assign result.valid     = valid_s2;
	assign result.command   = command_s2;
	assign result.amount    = amount_s2;
	assign result.speed     = speed_s2;
	assign result.mode      = mode_s2;
	assign result.event_res = event_res_s2;

endmodule

// ----- rtl/core/rrms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrms_checker
// Port-level checks on the result channel of the mode sequencer.
// ----------------------------------------------------------------------------
module rrms_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [2:0]        res_command,
	input logic signed [8:0] res_amount,
	input logic [6:0]        res_speed,
	input logic [1:0]        res_mode
);
	import rrms_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_command)
			&& $stable(res_amount) && $stable(res_speed))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_command == CMD_NONE || res_command == CMD_STOP)
			|-> res_amount == '0 && res_speed == '0)
		else $error("none or stop carries payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_command != CMD_DRIVE_DIST && res_command != CMD_ROTATE_ANGLE
			|-> res_speed == '0)
		else $error("speed set on a speed-less command");

	// distance and angle moves come only from the autonomous patterns
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_command == CMD_DRIVE_DIST || res_command == CMD_ROTATE_ANGLE)
			|-> res_mode == MODE_AUTO)
		else $error("pattern move outside autonomous mode");

endmodule

bind robot_roam_mode_sequencer rrms_checker u_rrms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_command (result.command),
	.res_amount  (result.amount),
	.res_speed   (result.speed),
	.res_mode    (result.mode)
);

// ----- test/tb_robot_roam_mode_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_robot_roam_mode_sequencer
// Self-checking bench for the roam mode sequencer. A short table of directed
// requests walks the manual, idle and boundary recovery paths, then six phases
// of random requests run under different register settings and handshake
// idling. Each accepted request is run through a local model of the mode and
// pattern steps; each result is checked in order against it or its directed row.
// ----------------------------------------------------------------------------
module tb_robot_roam_mode_sequencer;
	import rrms_pkg::*;

	localparam int PROX_W      = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 275;
	localparam int HOLD_LEN    = 300;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [1:0] HEAD_NONE = 2'd0;
	localparam logic [1:0] HEAD_BAD  = 2'd3;

	typedef struct {
		logic [2:0]        opcode;
		logic signed [7:0] mspeed;
		logic [PROX_W-1:0] prox;
		logic              bound;
		logic              drv_idle;
		logic [1:0]        heading;
		logic              coin;
		logic [6:0]        pick;
	} req_t;

	typedef struct {
		logic [2:0]        command;
		logic signed [8:0] amount;
		logic [6:0]        speed;
		logic [1:0]        mode;
		logic [1:0]        evt;
	} res_t;

	typedef struct {
		req_t r;
		bit   chk;
		res_t w;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [PROX_W-1:0] cfg_data;

	rrms_item_if #(.PROX_BITS(PROX_W)) req_ch ();
	rrms_result_if res_ch ();

	robot_roam_mode_sequencer #(.PROX_BITS(PROX_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (req_ch),
		.result    (res_ch)
	);

	// sequencer model state
	mode_t       cur_mode     = MODE_IDLE;
	pattern_t    cur_pat      = PAT_FORWARD;
	fwd_step_t   fwd          = FWD_BEGIN;
	seq_step_t   bko          = SEQ_BEGIN;
	seq_step_t   rec          = SEQ_BEGIN;
	logic [1:0]  held_heading = HEAD_NONE;
	event_t      latched_ev   = EV_NONE;

	logic [6:0]        spd_low  = RST_DRIVE_LOW;
	logic [6:0]        spd_high = RST_DRIVE_HIGH;
	logic [6:0]        spd_rot  = RST_ROTATE_HIGH;
	logic [PROX_W-1:0] near_thr = PROX_W'(RST_NEAR_THRESH);

	res_t next_res;
	res_t expect_q[$];
	row_t dir_q[$];

	bit   offer_chk;
	res_t offer_want;

	int gap_pct;
	int stall_pct;
	int hold_cycles;
	int errs   = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	function automatic void issue(input cmd_t c, input int amt, input logic [6:0] spd);
		next_res.command = c;
		next_res.amount  = 9'(amt);
		next_res.speed   = spd;
	endfunction

	function automatic int turn_angle(input int low, input int span, input logic [6:0] pick);
		return low + ((int'(pick) < span) ? int'(pick) : span);
	endfunction

	function automatic void enter_pat(input pattern_t p);
		case (p)
			PAT_BACKOFF: begin
				latched_ev = EV_CLOSE;
				bko = SEQ_BEGIN;
			end
			PAT_RECOVER: begin
				latched_ev = EV_BOUNDARY;
				rec = SEQ_BEGIN;
			end
			default: fwd = FWD_BEGIN;
		endcase
		cur_pat = p;
	endfunction

	// one request through the mode and pattern steps; result left in next_res
	function automatic void roam_step(input req_t r);
		logic   near_hit;
		event_t ev_seen;
		int     ang;
		near_hit = r.prox < near_thr;
		issue(CMD_NONE, 0, 7'd0);
		case (r.opcode)
			OP_TICK: begin
				if (cur_mode == MODE_AUTO) begin
					case (cur_pat)
						PAT_FORWARD: begin
							case (fwd)
								FWD_BEGIN: fwd = FWD_DRIVE;
								FWD_DRIVE: begin
									issue(CMD_DRIVE_SPEED, int'(spd_high), 7'd0);
									fwd = FWD_WAIT;
								end
								FWD_WAIT: begin
									// boundary checked last, so it wins
									if (near_hit) enter_pat(PAT_BACKOFF);
									if (r.bound) enter_pat(PAT_RECOVER);
								end
								default: ;
							endcase
						end
						PAT_BACKOFF: begin
							case (bko)
								SEQ_BEGIN: bko = SEQ_STOP;
								SEQ_STOP: begin
									issue(CMD_STOP, 0, 7'd0);
									bko = SEQ_WAIT_STOP;
								end
								SEQ_WAIT_STOP: if (r.drv_idle) bko = SEQ_MOVE;
								SEQ_MOVE: begin
									issue(CMD_DRIVE_DIST, -200, spd_low);
									bko = SEQ_WAIT_MOVE;
								end
								SEQ_WAIT_MOVE: begin
									if (r.bound) enter_pat(PAT_RECOVER);
									if (r.drv_idle) bko = SEQ_TURN;
								end
								SEQ_TURN: begin
									ang = r.coin ? turn_angle(90, 30, r.pick)
										: turn_angle(-120, 30, r.pick);
									issue(CMD_ROTATE_ANGLE, ang, spd_rot);
									bko = SEQ_WAIT_TURN;
								end
								SEQ_WAIT_TURN: if (r.drv_idle) enter_pat(PAT_FORWARD);
								default: ;
							endcase
						end
						PAT_RECOVER: begin
							case (rec)
								SEQ_BEGIN: begin
									held_heading = r.heading;
									rec = SEQ_STOP;
								end
								SEQ_STOP: begin
									issue(CMD_STOP, 0, 7'd0);
									rec = SEQ_WAIT_STOP;
								end
								SEQ_WAIT_STOP: if (r.drv_idle) rec = SEQ_MOVE;
								SEQ_MOVE: begin
									// stopped or bad heading: no move at all
									if (held_heading == HEAD_FORWARD)
										issue(CMD_DRIVE_DIST, -100, spd_low);
									else if (held_heading == HEAD_REVERSE)
										issue(CMD_DRIVE_DIST, 200, spd_low);
									rec = SEQ_WAIT_MOVE;
								end
								SEQ_WAIT_MOVE: begin
									if (near_hit) enter_pat(PAT_BACKOFF);
									if (r.drv_idle) rec = SEQ_TURN;
								end
								SEQ_TURN: begin
									ang = 0;
									if (held_heading == HEAD_FORWARD)
										ang = r.coin ? turn_angle(45, 90, r.pick)
											: turn_angle(-135, 90, r.pick);
									else if (held_heading == HEAD_REVERSE)
										ang = turn_angle(-60, 120, r.pick);
									issue(CMD_ROTATE_ANGLE, ang, spd_rot);
									rec = SEQ_WAIT_TURN;
								end
								SEQ_WAIT_TURN: if (r.drv_idle) enter_pat(PAT_FORWARD);
								default: ;
							endcase
						end
						default: ;
					endcase
				end else if (cur_mode == MODE_MANUAL) begin
					if (near_hit && r.heading == HEAD_FORWARD) begin
						latched_ev = EV_CLOSE;
						issue(CMD_STOP, 0, 7'd0);
						cur_mode = MODE_IDLE;
					end
				end
			end
			OP_START: begin
				if (cur_mode == MODE_IDLE) begin
					enter_pat(PAT_FORWARD);
					cur_mode = MODE_AUTO;
				end
			end
			OP_HALT: begin
				if (cur_mode == MODE_AUTO) begin
					issue(CMD_STOP, 0, 7'd0);
					cur_mode = MODE_IDLE;
				end
			end
			OP_MANUAL_DRIVE, OP_MANUAL_ROTATE: begin
				if (cur_mode == MODE_IDLE || cur_mode == MODE_MANUAL) begin
					issue((r.opcode == OP_MANUAL_DRIVE) ? CMD_DRIVE_SPEED : CMD_ROTATE_SPEED,
						int'(r.mspeed), 7'd0);
					cur_mode = MODE_MANUAL;
				end
			end
			OP_MANUAL_HALT: begin
				if (cur_mode == MODE_MANUAL) begin
					issue(CMD_STOP, 0, 7'd0);
					cur_mode = MODE_IDLE;
				end
			end
			default: ;
		endcase
		ev_seen = latched_ev;
		if (r.opcode == OP_READ_EVENT) latched_ev = EV_NONE;
		next_res.mode = cur_mode;
		next_res.evt  = ev_seen;
	endfunction

	function automatic res_t want(input cmd_t c, input int amt, input int spd,
		input mode_t m, input event_t e);
		res_t w;
		w.command = c;
		w.amount  = 9'(amt);
		w.speed   = 7'(spd);
		w.mode    = m;
		w.evt     = e;
		return w;
	endfunction

	function automatic void add_row(input logic [2:0] op, input int ms, input int px,
		input bit bd, input bit di, input logic [1:0] hd, input bit cn, input int pk,
		input bit chk, input res_t w);
		row_t row;
		row.r.opcode   = op;
		row.r.mspeed   = 8'(ms);
		row.r.prox     = PROX_W'(px);
		row.r.bound    = bd;
		row.r.drv_idle = di;
		row.r.heading  = hd;
		row.r.coin     = cn;
		row.r.pick     = 7'(pk);
		row.chk        = chk;
		row.w          = w;
		dir_q.push_back(row);
	endfunction

	// mostly ticks with plausible sensor readings, so the patterns run deep
	function automatic req_t roam_item();
		req_t r;
		int   sel;
		sel = $urandom_range(99);
		if (sel < 66)      r.opcode = OP_TICK;
		else if (sel < 74) r.opcode = OP_START;
		else if (sel < 77) r.opcode = OP_HALT;
		else if (sel < 81) r.opcode = OP_MANUAL_DRIVE;
		else if (sel < 85) r.opcode = OP_MANUAL_ROTATE;
		else if (sel < 89) r.opcode = OP_MANUAL_HALT;
		else if (sel < 98) r.opcode = OP_READ_EVENT;
		else               r.opcode = OP_UNUSED;
		if ($urandom_range(99) < 85) r.mspeed = 8'(int'($urandom_range(200)) - 100);
		else                         r.mspeed = 8'($urandom);
		sel = $urandom_range(99);
		if (sel < 10)
			r.prox = PROX_W'($urandom);
		else if (sel < 24 && near_thr != 0)
			r.prox = PROX_W'($urandom_range(int'(near_thr) - 1));
		else
			r.prox = PROX_W'($urandom_range(1023, int'(near_thr)));
		r.bound    = ($urandom_range(99) < 8);
		r.drv_idle = ($urandom_range(99) < 75);
		sel = $urandom_range(99);
		if (sel < 45)      r.heading = HEAD_FORWARD;
		else if (sel < 90) r.heading = HEAD_REVERSE;
		else if (sel < 97) r.heading = HEAD_NONE;
		else               r.heading = HEAD_BAD;
		r.coin = 1'($urandom_range(1));
		r.pick = 7'($urandom_range(127));
		return r;
	endfunction

	function automatic void note_err(input string msg);
		if (errs < 10) $display("%0t mismatch: %s", $time, msg);
		errs++;
	endfunction

	task automatic offer(input req_t r, input bit chk, input res_t w);
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.opcode         <= r.opcode;
		req_ch.manual_speed   <= r.mspeed;
		req_ch.proximity      <= r.prox;
		req_ch.off_boundary   <= r.bound;
		req_ch.driver_idle    <= r.drv_idle;
		req_ch.driver_heading <= r.heading;
		req_ch.coin           <= r.coin;
		req_ch.pick           <= r.pick;
		offer_chk             <= chk;
		offer_want            <= w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(input logic [PROX_W-1:0] lo, input logic [PROX_W-1:0] hi,
		input logic [PROX_W-1:0] rot, input logic [PROX_W-1:0] thr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DRIVE_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_DRIVE_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= CFG_ROTATE_HIGH;
		cfg_data  <= rot;
		@(posedge clk);
		cfg_index <= CFG_NEAR_THRESH;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// register writes, accepted requests and accepted results
	always @(posedge clk) begin : monitor
		req_t r;
		res_t w;
		if (cfg_we) begin
			case (cfg_index)
				CFG_DRIVE_LOW:   spd_low  = cfg_data[6:0];
				CFG_DRIVE_HIGH:  spd_high = cfg_data[6:0];
				CFG_ROTATE_HIGH: spd_rot  = cfg_data[6:0];
				default:         near_thr = cfg_data;
			endcase
		end
		if (req_ch.valid && req_ch.ready) begin
			r.opcode   = req_ch.opcode;
			r.mspeed   = req_ch.manual_speed;
			r.prox     = req_ch.proximity;
			r.bound    = req_ch.off_boundary;
			r.drv_idle = req_ch.driver_idle;
			r.heading  = req_ch.driver_heading;
			r.coin     = req_ch.coin;
			r.pick     = req_ch.pick;
			roam_step(r);
			expect_q.push_back(offer_chk ? offer_want : next_res);
		end
		if (res_ch.valid && res_ch.ready) begin
			if (expect_q.size() == 0) begin
				note_err($sformatf("result with no request pending: cmd=%0d amt=%0d",
					res_ch.command, res_ch.amount));
			end else begin
				w = expect_q.pop_front();
				if (res_ch.command !== w.command || res_ch.amount !== w.amount ||
					res_ch.speed !== w.speed || res_ch.mode !== w.mode ||
					res_ch.event_res !== w.evt)
					note_err($sformatf(
						"exp cmd=%0d amt=%0d spd=%0d mode=%0d ev=%0d, got %0d %0d %0d %0d %0d",
						w.command, w.amount, w.speed, w.mode, w.evt, res_ch.command,
						res_ch.amount, res_ch.speed, res_ch.mode, res_ch.event_res));
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		res_t blank;
		blank = want(CMD_NONE, 0, 0, MODE_IDLE, EV_NONE);
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_DRIVE_LOW;
		cfg_data              = '0;
		req_ch.valid          = 1'b0;
		req_ch.opcode         = OP_TICK;
		req_ch.manual_speed   = '0;
		req_ch.proximity      = '0;
		req_ch.off_boundary   = 1'b0;
		req_ch.driver_idle    = 1'b0;
		req_ch.driver_heading = HEAD_NONE;
		req_ch.coin           = 1'b0;
		req_ch.pick           = '0;
		res_ch.ready          = 1'b0;
		offer_chk             = 1'b0;
		offer_want            = blank;
		gap_pct               = 0;
		stall_pct             = 0;
		hold_cycles           = 0;

		// ignored requests and manual mode
		add_row(OP_READ_EVENT, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1, blank);
		add_row(OP_HALT, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1, blank);
		add_row(OP_MANUAL_HALT, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1, blank);
		add_row(OP_UNUSED, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1, blank);
		add_row(OP_MANUAL_DRIVE, -128, 0, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_DRIVE_SPEED, -128, 0, MODE_MANUAL, EV_NONE));
		add_row(OP_MANUAL_ROTATE, 127, 1023, 1, 1, HEAD_BAD, 1, 127, 1,
			want(CMD_ROTATE_SPEED, 127, 0, MODE_MANUAL, EV_NONE));
		add_row(OP_START, 0, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_MANUAL, EV_NONE));
		// close obstacle ahead while driving by hand
		add_row(OP_TICK, 0, 0, 0, 0, HEAD_FORWARD, 0, 0, 1,
			want(CMD_STOP, 0, 0, MODE_IDLE, EV_CLOSE));
		add_row(OP_READ_EVENT, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_IDLE, EV_CLOSE));
		add_row(OP_READ_EVENT, 0, 0, 0, 0, HEAD_NONE, 0, 0, 1, blank);
		add_row(OP_MANUAL_ROTATE, -100, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_ROTATE_SPEED, -100, 0, MODE_MANUAL, EV_NONE));
		add_row(OP_TICK, 0, 0, 0, 0, HEAD_REVERSE, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_MANUAL, EV_NONE));
		add_row(OP_MANUAL_HALT, 0, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_STOP, 0, 0, MODE_IDLE, EV_NONE));
		// autonomous: cruise, then obstacle and boundary together
		add_row(OP_START, 0, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_AUTO, EV_NONE));
		add_row(OP_MANUAL_DRIVE, 50, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_AUTO, EV_NONE));
		add_row(OP_TICK, 0, 1023, 0, 0, HEAD_FORWARD, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_AUTO, EV_NONE));
		add_row(OP_TICK, 0, 1023, 0, 0, HEAD_FORWARD, 0, 0, 1,
			want(CMD_DRIVE_SPEED, 40, 0, MODE_AUTO, EV_NONE));
		add_row(OP_TICK, 0, 0, 1, 0, HEAD_FORWARD, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_AUTO, EV_BOUNDARY));
		// recovery with a stopped heading latched
		add_row(OP_TICK, 0, 1023, 0, 0, HEAD_NONE, 0, 0, 0, blank);
		add_row(OP_TICK, 0, 1023, 0, 0, HEAD_NONE, 0, 0, 1,
			want(CMD_STOP, 0, 0, MODE_AUTO, EV_BOUNDARY));
		add_row(OP_TICK, 0, 1023, 0, 1, HEAD_NONE, 0, 0, 0, blank);
		add_row(OP_TICK, 0, 1023, 0, 1, HEAD_FORWARD, 0, 0, 1,
			want(CMD_NONE, 0, 0, MODE_AUTO, EV_BOUNDARY));
		add_row(OP_TICK, 0, 1023, 0, 1, HEAD_FORWARD, 0, 0, 0, blank);
		add_row(OP_TICK, 0, 1023, 0, 1, HEAD_FORWARD, 1, 127, 1,
			want(CMD_ROTATE_ANGLE, 0, 40, MODE_AUTO, EV_BOUNDARY));
		add_row(OP_HALT, 0, 1023, 0, 1, HEAD_NONE, 0, 0, 1,
			want(CMD_STOP, 0, 0, MODE_IDLE, EV_BOUNDARY));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_q[i]) offer(dir_q[i].r, dir_q[i].chk, dir_q[i].w);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_regs('0, '0, '0, '0);
				1: load_regs(10'd100, 10'd100, 10'd100, 10'd1023);
				2: load_regs(10'h3FF, 10'h3E4, 10'h380, 10'h200);
				3: load_regs(PROX_W'($urandom_range(100)), PROX_W'($urandom_range(100)),
					PROX_W'($urandom_range(100)), PROX_W'($urandom_range(1023)));
				4: load_regs(PROX_W'(RST_DRIVE_LOW), PROX_W'(RST_DRIVE_HIGH),
					PROX_W'(RST_ROTATE_HIGH), PROX_W'(RST_NEAR_THRESH));
				default: load_regs(PROX_W'($urandom), PROX_W'($urandom),
					PROX_W'($urandom), PROX_W'($urandom));
			endcase
			case (ph % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 62;
					stall_pct = 0;
				end
				2: begin
					gap_pct   = 0;
					stall_pct = 62;
				end
				default: begin
					gap_pct   = 38;
					stall_pct = 38;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long result hold-off while requests keep coming: fills the pipe
				if (ph == 0 && n == 60) begin
					req_ch.valid <= 1'b0;
					@(negedge clk) hold_cycles = HOLD_LEN;
					@(posedge clk);
				end
				offer(roam_item(), 1'b0, blank);
			end
			drain();
		end

		if (errs == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
